// File: rtl/core/glyph_blit_clip_matrix_map_unit_macros.svh
// ----------------------------------------------------------------------------
// Glyph blit unit assertion macros
// Shared assertion forms for the glyph blit unit checkers.
// ----------------------------------------------------------------------------
`ifndef GLYPH_BLIT_CLIP_MATRIX_MAP_UNIT_MACROS_SVH
`define GLYPH_BLIT_CLIP_MATRIX_MAP_UNIT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define GBCM_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define GBCM_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/gbcm_pkg.sv
// ----------------------------------------------------------------------------
// Glyph blit package
// Types, stream layout constants, the matrix mapping ROM and row helpers.
// ----------------------------------------------------------------------------
package gbcm_pkg;

	// Input stream layout, lowest bit first.
	localparam int BITS_W      = 56;
	localparam int WIDTH_W     = 3;
	localparam int SHIFT_W     = 3;
	localparam int POSX_W      = 6;
	localparam int POSY_W      = 5;
	localparam int COLOR_W     = 16;
	localparam int BITS_LSB    = 0;
	localparam int WIDTH_LSB   = BITS_LSB + BITS_W;
	localparam int SHIFT_LSB   = WIDTH_LSB + WIDTH_W;
	localparam int POSX_LSB    = SHIFT_LSB + SHIFT_W;
	localparam int POSY_LSB    = POSX_LSB + POSX_W;
	localparam int COLOR_LSB   = POSY_LSB + POSY_W;
	localparam int IN_USED_W   = COLOR_LSB + COLOR_W;
	localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

	// Output stream layout, lowest bit first.
	localparam int ADDR_W      = 8;
	localparam int ADV_W       = 3;
	localparam int OUT_USED_W  = ADDR_W + COLOR_W + ADV_W;
	localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

	localparam int GLYPH_ROWS  = 7;
	localparam int MAX_WRITES  = 49;
	localparam int WCNT_W      = 6;
	localparam int CRD_W       = 7;   // signed coordinate arithmetic
	localparam int RSHIFT_W    = 4;   // total row shift, up to 13 for a visible glyph

	localparam int ROM_ROWS    = 7;
	localparam int ROM_COLS    = 26;

	localparam logic [7:0] MAP_ROM [ROM_ROWS][ROM_COLS] = '{
		'{8'hC7, 8'hC6, 8'hC5, 8'hC4, 8'hC3, 8'hC2, 8'hC1, 8'hC0, 8'hCF, 8'hCE, 8'hCD,
		  8'hCC, 8'hCB, 8'hF7, 8'hF6, 8'hF5, 8'hF4, 8'hF3, 8'hF2, 8'hF1, 8'hF0, 8'hFF,
		  8'hFE, 8'hFD, 8'hFC, 8'hFB},
		'{8'hD7, 8'hD6, 8'hD5, 8'hD4, 8'hD3, 8'hD2, 8'hD1, 8'hD0, 8'hDF, 8'hDE, 8'hDD,
		  8'hDC, 8'hDB, 8'h17, 8'h16, 8'h15, 8'h14, 8'h13, 8'h12, 8'h11, 8'h10, 8'h1F,
		  8'h1E, 8'h1D, 8'h1C, 8'h1B},
		'{8'hB7, 8'hB6, 8'hB5, 8'hB4, 8'hB3, 8'hB2, 8'hB1, 8'hB0, 8'hBF, 8'hBE, 8'hBD,
		  8'hBC, 8'hBB, 8'h27, 8'h26, 8'h25, 8'h24, 8'h23, 8'h22, 8'h21, 8'h20, 8'h2F,
		  8'h2E, 8'h2D, 8'h2C, 8'h2B},
		'{8'hA7, 8'hA6, 8'hA5, 8'hA4, 8'hA3, 8'hA2, 8'hA1, 8'hA0, 8'hAF, 8'hAE, 8'hAD,
		  8'hAC, 8'hAB, 8'h07, 8'h06, 8'h05, 8'h04, 8'h03, 8'h02, 8'h01, 8'h00, 8'h0F,
		  8'h0E, 8'h0D, 8'h0C, 8'h0B},
		'{8'h87, 8'h86, 8'h85, 8'h84, 8'h83, 8'h82, 8'h81, 8'h80, 8'h8F, 8'h8E, 8'h8D,
		  8'h8C, 8'h8B, 8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30, 8'h3F,
		  8'h3E, 8'h3D, 8'h3C, 8'h3B},
		'{8'h97, 8'h96, 8'h95, 8'h94, 8'h93, 8'h92, 8'h91, 8'h90, 8'h9F, 8'h9E, 8'h9D,
		  8'h9C, 8'h9B, 8'h57, 8'h56, 8'h55, 8'h54, 8'h53, 8'h52, 8'h51, 8'h50, 8'h5F,
		  8'h5E, 8'h5D, 8'h5C, 8'h5B},
		'{8'h77, 8'h76, 8'h75, 8'h74, 8'h73, 8'h72, 8'h71, 8'h70, 8'h7F, 8'h7E, 8'h7D,
		  8'h7C, 8'h7B, 8'h47, 8'h46, 8'h45, 8'h44, 8'h43, 8'h42, 8'h41, 8'h40, 8'h4F,
		  8'h4E, 8'h4D, 8'h4C, 8'h4B}
	};

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // capture the input item
		logic setup;  // latch the clipped window and the first row
		logic step;   // visit one pixel position
		logic mark;   // emit the end marker
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic visible;   // clipped window holds at least one pixel
		logic col_end;   // current column is the last of the window
		logic row_end;   // current row is the last of the window
		logic out_free;  // output register can take a result this cycle
	} dp_status_t;

	// Framebuffer index for a screen position; positions outside the ROM map to zero.
	function automatic logic [ADDR_W-1:0] map_lookup(input int row, input int col);
		if (row >= ROM_ROWS || col >= ROM_COLS) begin
			return '0;
		end
		return MAP_ROM[3'(row)][5'(col)];
	endfunction

	// One glyph row after the right shift; rows past the seventh read as zero.
	function automatic logic [7:0] glyph_row_sel(input logic [BITS_W-1:0] bits,
			input logic [2:0] r, input logic [RSHIFT_W-1:0] sh);
		logic [BITS_W-1:0] t;
		t = bits >> {r, 3'b000};
		if (int'(r) >= GLYPH_ROWS || sh[RSHIFT_W-1]) begin
			return '0;
		end
		return t[7:0] >> sh[RSHIFT_W-2:0];
	endfunction

endpackage

// File: rtl/core/gbcm_ctrl.sv
// ----------------------------------------------------------------------------
// Glyph blit controller
// Sequences capture, clip setup, the pixel scan and the end marker.
// ----------------------------------------------------------------------------
module gbcm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	output gbcm_pkg::dp_cmd_t     cmd,
	input  gbcm_pkg::dp_status_t  status
);
	import gbcm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_SCAN,
		ST_MARK
	} state_t;

	state_t state_q;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd       = '0;
		cmd.load  = (state_q == ST_IDLE) && s_tvalid;
		cmd.setup = (state_q == ST_SETUP);
		cmd.step  = (state_q == ST_SCAN) && status.out_free;
		cmd.mark  = (state_q == ST_MARK) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_SETUP;
				end
				ST_SETUP: begin
					state_q <= status.visible ? ST_SCAN : ST_MARK;
				end
				ST_SCAN: begin
					if (status.out_free && status.col_end && status.row_end) begin
						state_q <= ST_MARK;
					end
				end
				ST_MARK: begin
					if (status.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/gbcm_datapath.sv
// ----------------------------------------------------------------------------
// Glyph blit datapath
// Item registers, clipping, the column and row counters and the result register.
// ----------------------------------------------------------------------------
module gbcm_datapath #(
	parameter int MATRIX_COLS = 26,
	parameter int MATRIX_ROWS = 7,
	parameter int FONT_ROWS   = 7
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gbcm_pkg::dp_cmd_t                   cmd,
	output gbcm_pkg::dp_status_t                status,
	input  logic [gbcm_pkg::IN_TDATA_W-1:0]     item_data,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [gbcm_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic                                m_tuser,
	output logic                                m_tlast
);
	import gbcm_pkg::*;

	localparam int XW = $clog2(MATRIX_COLS + 1);
	localparam int YW = $clog2(MATRIX_ROWS + 1);
	localparam logic signed [CRD_W-1:0] SW_S = CRD_W'(MATRIX_COLS);
	localparam logic signed [CRD_W-1:0] SH_S = CRD_W'(MATRIX_ROWS);
	localparam logic signed [CRD_W-1:0] GH_S = CRD_W'(FONT_ROWS);
	localparam logic signed [CRD_W-1:0] ONE_S = CRD_W'(1);

	// Captured item.
	logic [BITS_W-1:0]  bits_q;
	logic [WIDTH_W-1:0] width_q;
	logic [SHIFT_W-1:0] gshift_q;
	logic [POSX_W-1:0]  pos_x_q;
	logic [POSY_W-1:0]  pos_y_q;
	logic [COLOR_W-1:0] color_q;

	// Scan state.
	logic [XW-1:0]       sx_q, x0_q, x_last_q;
	logic [YW-1:0]       sy_q, y_last_q;
	logic [2:0]          gr_q;
	logic [RSHIFT_W-1:0] shift_q;
	logic [7:0]          row_q;
	logic [WCNT_W-1:0]   wcnt_q;

	// Result register.
	logic                out_valid_q;
	logic                out_write_q;
	logic                out_last_q;
	logic [ADDR_W-1:0]   out_addr_q;
	logic [COLOR_W-1:0]  out_color_q;
	logic [ADV_W-1:0]    out_adv_q;

	// Clipping of the glyph window against the screen.
	logic signed [CRD_W-1:0] x_ext, y_ext, x_end_raw, y_end_raw;
	logic signed [CRD_W-1:0] x0, y0, x_end, y_end, x_neg, y_neg;
	logic [2:0]              first_row;
	logic [RSHIFT_W-1:0]     shift_sum;
	logic                    lit, col_end;

	always_comb begin
		x_ext     = {pos_x_q[POSX_W-1], pos_x_q};
		y_ext     = {{(CRD_W-POSY_W){pos_y_q[POSY_W-1]}}, pos_y_q};
		x_end_raw = x_ext + $signed({{(CRD_W-WIDTH_W){1'b0}}, width_q});
		y_end_raw = y_ext + GH_S;
		x_neg     = -x_ext;
		y_neg     = -y_ext;
		x0        = x_ext[CRD_W-1] ? '0 : x_ext;
		y0        = y_ext[CRD_W-1] ? '0 : y_ext;
		x_end     = (x_end_raw > SW_S) ? SW_S : x_end_raw;
		y_end     = (y_end_raw > SH_S) ? SH_S : y_end_raw;
		// Columns cut off at the left are pushed out of the row by extra shift.
		first_row = y_ext[CRD_W-1] ? y_neg[2:0] : 3'd0;
		shift_sum = {1'b0, gshift_q} + (x_ext[CRD_W-1] ? x_neg[RSHIFT_W-1:0] : '0);
	end

	assign col_end = (sx_q == x_last_q);
	assign lit     = row_q[0] && (int'(wcnt_q) < MAX_WRITES);

	always_comb begin
		status          = '0;
		status.visible  = (x0 < x_end) && (y0 < y_end);
		status.col_end  = col_end;
		status.row_end  = (sy_q == y_last_q);
		status.out_free = !out_valid_q || m_tready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bits_q   <= item_data[BITS_LSB +: BITS_W];
			width_q  <= item_data[WIDTH_LSB +: WIDTH_W];
			gshift_q <= item_data[SHIFT_LSB +: SHIFT_W];
			pos_x_q  <= item_data[POSX_LSB +: POSX_W];
			pos_y_q  <= item_data[POSY_LSB +: POSY_W];
			color_q  <= item_data[COLOR_LSB +: COLOR_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q     <= '0;
			x0_q     <= '0;
			x_last_q <= '0;
			sy_q     <= '0;
			y_last_q <= '0;
			gr_q     <= '0;
			shift_q  <= '0;
			row_q    <= '0;
			wcnt_q   <= '0;
		end else if (cmd.setup) begin
			sx_q     <= XW'(x0);
			x0_q     <= XW'(x0);
			x_last_q <= XW'(x_end - ONE_S);
			sy_q     <= YW'(y0);
			y_last_q <= YW'(y_end - ONE_S);
			gr_q     <= first_row;
			shift_q  <= shift_sum;
			row_q    <= glyph_row_sel(bits_q, first_row, shift_sum);
			wcnt_q   <= '0;
		end else if (cmd.step) begin
			if (lit) wcnt_q <= wcnt_q + 1'b1;
			if (col_end) begin
				sx_q  <= x0_q;
				sy_q  <= sy_q + 1'b1;
				gr_q  <= gr_q + 1'b1;
				row_q <= glyph_row_sel(bits_q, gr_q + 3'd1, shift_q);
			end else begin
				sx_q  <= sx_q + 1'b1;
				row_q <= row_q >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.step && lit) || cmd.mark) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && lit) begin
			out_write_q <= 1'b1;
			out_last_q  <= 1'b0;
			out_addr_q  <= map_lookup(int'(sy_q), int'(sx_q));
			out_color_q <= color_q;
			out_adv_q   <= '0;
		end else if (cmd.mark) begin
			out_write_q <= 1'b0;
			out_last_q  <= 1'b1;
			out_addr_q  <= '0;
			out_color_q <= '0;
			out_adv_q   <= width_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_write_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(OUT_TDATA_W-OUT_USED_W){1'b0}}, out_adv_q, out_color_q, out_addr_q};

endmodule

// File: rtl/core/glyph_blit_clip_matrix_map_unit.sv
// ----------------------------------------------------------------------------
// Glyph blit unit with clipping and matrix mapping
// Draws one glyph per input transfer into the LED matrix framebuffer.
// ----------------------------------------------------------------------------
// Usage: each slave transfer carries one glyph, its signed position and a
// color. The glyph is clipped against the screen, and every lit visible pixel
// leaves as one master transfer with m_tuser high (a framebuffer write whose
// address comes from the matrix mapping ROM). The run always ends with one
// marker transfer, m_tuser low and m_tlast high, that carries the advance.
// Writes go row by row from the top, left to right within a row.
// The item is captured and the window is clipped; then every pixel position
// of the clipped window is visited, lit or not, and last the marker is sent.
// A scan step that finds a lit pixel registers its write in the result
// register. s_tready is high only between glyphs.
// Reset clears the controller, the scan counters and the result valid flag;
// the item registers and the result payload are not reset.
// When the receiver stalls, the scan waits on the result register and holds.
// ----------------------------------------------------------------------------
module glyph_blit_clip_matrix_map_unit #(
	parameter int MATRIX_COLS = 26,
	parameter int MATRIX_ROWS = 7,
	parameter int FONT_ROWS   = 7
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// glyph_bits[55:0], width[58:56], shift[61:59], pos_x[67:62],
	// pos_y[72:68], draw_color[88:73], zero fill [95:89]
	input  logic [gbcm_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// pixel_address[7:0], pixel_color[23:8], advance[26:24], zero fill [31:27]
	output logic [gbcm_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// is_write[0]
	output logic                                m_tuser,
	output logic                                m_tlast
);
	import gbcm_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	gbcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.status   (status)
	);

	gbcm_datapath #(
		.MATRIX_COLS (MATRIX_COLS),
		.MATRIX_ROWS (MATRIX_ROWS),
		.FONT_ROWS   (FONT_ROWS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.item_data (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// File: rtl/core/gbcm_checker.sv
// ----------------------------------------------------------------------------
// Glyph blit port checker
// Watches the top level's ports and checks result form and item ordering.
// ----------------------------------------------------------------------------
`include "glyph_blit_clip_matrix_map_unit_macros.svh"

module gbcm_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [gbcm_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input logic                                m_tuser,
	input logic                                m_tlast
);
	import gbcm_pkg::*;

	// A stalled result must not change.
	`GBCM_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

	// Only the end marker closes a run, and the marker is never a write.
	`GBCM_ASSERT(a_marker_kind, clk, arst_n, m_tvalid |-> (m_tlast == !m_tuser), "marker and write flags disagree")

	// The marker carries only the advance.
	`GBCM_ASSERT(a_marker_clean, clk, arst_n, m_tvalid && m_tlast |-> m_tdata[ADDR_W+COLOR_W-1:0] == '0, "marker carries address or color")

	// A glyph is worked on alone: the input closes right after an accepted transfer.
	`GBCM_ASSERT(a_one_glyph, clk, arst_n, s_tvalid && s_tready |=> !s_tready, "second glyph accepted during a run")

	// No result is offered while reset is held.
	`GBCM_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !m_tvalid, "result offered during reset")

endmodule

bind glyph_blit_clip_matrix_map_unit gbcm_checker u_gbcm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
